/* src/kfvh_pkg.sv */
// Shared types and constants for the spanning-forest-with-hub block.
// Used by kfvh_ctrl, kfvh_dp and the top level; no dependencies.
package kfvh_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int NODE_W  = 11;                     // node numbers and counts
  localparam int WGT_W   = 16;
  localparam int FILL_W  = $clog2(MAX_EDGES + 1);  // 0..MAX_EDGES
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int PAR_D   = MAX_NODES + 1;
  localparam int PADDR_W = $clog2(PAR_D);
  localparam int DIG_W   = 8;                      // radix digit
  localparam int EDGE_W  = WGT_W + 2 * NODE_W;     // packed edge word
  localparam int TOT_W   = 33;                     // total plus carry for saturation

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 48;

  typedef enum logic [0:0] {
    REG_NODE_COUNT = 1'b0,
    REG_HUB_COST   = 1'b1
  } reg_t;

  typedef enum logic [4:0] {
    OP_CLR, OP_IDLE, OP_CC, OP_HR, OP_HC, OP_HW, OP_PR, OP_PW,
    OP_SR, OP_SC, OP_SW, OP_KR, OP_KC, OP_FR, OP_FC, OP_PCR,
    OP_PCW, OP_UN, OP_LR, OP_LC, OP_DONE
  } op_t;

  typedef struct packed {
    logic clr_last;   // parent clearing sweep at last entry
    logic didx_last;  // digit counter at last bucket
    logic idx_end;    // edge index reached fill
    logic pass;       // second radix pass
    logic edge_ok;    // fetched edge is a candidate
    logic root_hit;   // parent of cur is cur
    logic comp_end;   // compression walk reached the root
    logic side;       // working on endpoint b
    logic node_end;   // node counter past node count
    logic out_busy;   // result register still held
  } stat_t;

  // Packed edge: weight lowest, then a, then b
  function automatic logic [WGT_W-1:0] edge_wgt(input logic [EDGE_W-1:0] e);
    return e[WGT_W-1:0];
  endfunction

  function automatic logic [NODE_W-1:0] edge_a(input logic [EDGE_W-1:0] e);
    return e[WGT_W +: NODE_W];
  endfunction

  function automatic logic [NODE_W-1:0] edge_b(input logic [EDGE_W-1:0] e);
    return e[WGT_W + NODE_W +: NODE_W];
  endfunction

endpackage

/* src/kfvh_ctrl.sv */
// Sequencer for load, radix sort, Kruskal, root count and table clearing.
// Depends on kfvh_pkg; drives kfvh_dp through op and reads its status.
module kfvh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tlast,
  input  kfvh_pkg::stat_t st,
  output logic            s_tready,
  output kfvh_pkg::op_t   op
);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_CC, ST_HR, ST_HC, ST_HW, ST_PR, ST_PW,
    ST_SR, ST_SC, ST_SW, ST_KR, ST_KC, ST_FR, ST_FC, ST_PCR,
    ST_PCW, ST_UN, ST_LR, ST_LC, ST_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:  if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid && s_tlast) state_next = ST_CC;
      ST_CC:   if (st.didx_last) state_next = ST_HR;
      ST_HR:   state_next = st.idx_end ? ST_PR : ST_HC;
      ST_HC:   state_next = ST_HW;
      ST_HW:   state_next = ST_HR;
      ST_PR:   state_next = ST_PW;
      ST_PW:   state_next = st.didx_last ? ST_SR : ST_PR;
      ST_SR: begin
        if (st.idx_end) state_next = st.pass ? ST_KR : ST_CC;
        else            state_next = ST_SC;
      end
      ST_SC:   state_next = ST_SW;
      ST_SW:   state_next = ST_SR;
      ST_KR:   state_next = st.idx_end ? ST_LR : ST_KC;
      ST_KC:   state_next = st.edge_ok ? ST_FR : ST_KR;
      ST_FR:   state_next = ST_FC;
      ST_FC:   state_next = st.root_hit ? ST_PCR : ST_FR;
      ST_PCR:  state_next = ST_PCW;
      ST_PCW: begin
        if (st.comp_end) state_next = st.side ? ST_UN : ST_FR;
        else             state_next = ST_PCR;
      end
      ST_UN:   state_next = ST_KR;
      ST_LR:   state_next = st.node_end ? ST_DONE : ST_LC;
      ST_LC:   state_next = ST_LR;
      ST_DONE: if (!st.out_busy) state_next = ST_CLR;
      default: state_next = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_CLR:  op = kfvh_pkg::OP_CLR;
      ST_IDLE: op = kfvh_pkg::OP_IDLE;
      ST_CC:   op = kfvh_pkg::OP_CC;
      ST_HR:   op = kfvh_pkg::OP_HR;
      ST_HC:   op = kfvh_pkg::OP_HC;
      ST_HW:   op = kfvh_pkg::OP_HW;
      ST_PR:   op = kfvh_pkg::OP_PR;
      ST_PW:   op = kfvh_pkg::OP_PW;
      ST_SR:   op = kfvh_pkg::OP_SR;
      ST_SC:   op = kfvh_pkg::OP_SC;
      ST_SW:   op = kfvh_pkg::OP_SW;
      ST_KR:   op = kfvh_pkg::OP_KR;
      ST_KC:   op = kfvh_pkg::OP_KC;
      ST_FR:   op = kfvh_pkg::OP_FR;
      ST_FC:   op = kfvh_pkg::OP_FC;
      ST_PCR:  op = kfvh_pkg::OP_PCR;
      ST_PCW:  op = kfvh_pkg::OP_PCW;
      ST_UN:   op = kfvh_pkg::OP_UN;
      ST_LR:   op = kfvh_pkg::OP_LR;
      ST_LC:   op = kfvh_pkg::OP_LC;
      ST_DONE: op = kfvh_pkg::OP_DONE;
      default: op = kfvh_pkg::OP_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

endmodule

/* src/kfvh_dp.sv */
// Datapath: edge stores, radix bucket counters, parent table, accumulators
// and the result register. Depends on kfvh_pkg; sequenced by kfvh_ctrl.
module kfvh_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  kfvh_pkg::op_t                       op,
  input  logic                                in_take,
  input  logic                                edge_valid,
  input  logic [kfvh_pkg::NODE_W-1:0]         endpoint_a,
  input  logic [kfvh_pkg::NODE_W-1:0]         endpoint_b,
  input  logic [kfvh_pkg::WGT_W-1:0]          edge_weight,
  input  logic                                cfg_take,
  input  kfvh_pkg::reg_t                      cfg_index,
  input  logic [kfvh_pkg::WGT_W-1:0]          cfg_data,
  input  logic                                out_take,
  output logic                                out_valid,
  output logic [31:0]                         total_cost,
  output logic [kfvh_pkg::NODE_W-1:0]         hub_links,
  output logic                                overflow,
  output kfvh_pkg::stat_t                     st
);

  logic [kfvh_pkg::EDGE_W-1:0] mem_a [kfvh_pkg::MAX_EDGES];
  logic [kfvh_pkg::EDGE_W-1:0] mem_b [kfvh_pkg::MAX_EDGES];
  logic [kfvh_pkg::FILL_W-1:0] cnt_mem [2**kfvh_pkg::DIG_W];
  logic [kfvh_pkg::NODE_W-1:0] par_mem [kfvh_pkg::PAR_D];

  logic [kfvh_pkg::EDGE_W-1:0] rd_a, rd_b, ew, src;
  logic [kfvh_pkg::FILL_W-1:0] rd_cnt, run, fill, idx;
  logic [kfvh_pkg::NODE_W-1:0] rd_par, cur, root_a, root_b, root_sel, nidx, n_eff;
  logic [kfvh_pkg::NODE_W-1:0] node_count, links, ka, kb;
  logic [kfvh_pkg::WGT_W-1:0]  hub_cost;
  logic [kfvh_pkg::DIG_W-1:0]  didx, dig, src_dig;
  logic [kfvh_pkg::TOT_W-1:0]  total;
  logic                        pass, lost, side;

  assign src      = pass ? rd_b : rd_a;
  assign src_dig  = pass ? src[15:8] : src[7:0];
  assign root_sel = side ? root_b : root_a;
  assign n_eff    = (node_count > kfvh_pkg::NODE_W'(kfvh_pkg::MAX_NODES)) ?
                    kfvh_pkg::NODE_W'(kfvh_pkg::MAX_NODES) : node_count;
  assign ka       = kfvh_pkg::edge_a(rd_a);
  assign kb       = kfvh_pkg::edge_b(rd_a);

  assign st.clr_last  = (nidx == kfvh_pkg::NODE_W'(kfvh_pkg::MAX_NODES));
  assign st.didx_last = (didx == '1);
  assign st.idx_end   = (idx == fill);
  assign st.pass      = pass;
  assign st.edge_ok   = (ka != '0) && (ka <= n_eff) && (kb != '0) && (kb <= n_eff) &&
                        (ka != kb) && (kfvh_pkg::edge_wgt(rd_a) < hub_cost);
  assign st.root_hit  = (rd_par == cur);
  assign st.comp_end  = (cur == root_sel);
  assign st.side      = side;
  assign st.node_end  = (nidx > n_eff);
  assign st.out_busy  = out_valid;

  // Edge store A: loading and second radix pass write; histogram/scatter/Kruskal read
  always_ff @(posedge clk) begin
    if (op == kfvh_pkg::OP_IDLE && in_take && edge_valid &&
        fill != kfvh_pkg::FILL_W'(kfvh_pkg::MAX_EDGES)) begin
      mem_a[fill[kfvh_pkg::EADDR_W-1:0]] <= {endpoint_b, endpoint_a, edge_weight};
    end else if (op == kfvh_pkg::OP_SW && pass) begin
      mem_a[rd_cnt[kfvh_pkg::EADDR_W-1:0]] <= ew;
    end
    rd_a <= mem_a[idx[kfvh_pkg::EADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (op == kfvh_pkg::OP_SW && !pass) begin
      mem_b[rd_cnt[kfvh_pkg::EADDR_W-1:0]] <= ew;
    end
    rd_b <= mem_b[idx[kfvh_pkg::EADDR_W-1:0]];
  end

  // Bucket counters
  always_ff @(posedge clk) begin
    case (op)
      kfvh_pkg::OP_CC: cnt_mem[didx] <= '0;
      kfvh_pkg::OP_HW: cnt_mem[dig]  <= rd_cnt + 1'b1;
      kfvh_pkg::OP_PW: cnt_mem[didx] <= run;
      kfvh_pkg::OP_SW: cnt_mem[dig]  <= rd_cnt + 1'b1;
      default: ;
    endcase
    case (op)
      kfvh_pkg::OP_PR: rd_cnt <= cnt_mem[didx];
      default:         rd_cnt <= cnt_mem[src_dig];
    endcase
  end

  // Parent table
  always_ff @(posedge clk) begin
    case (op)
      kfvh_pkg::OP_CLR: par_mem[nidx] <= nidx;
      kfvh_pkg::OP_PCW: if (!st.comp_end) par_mem[cur] <= root_sel;
      kfvh_pkg::OP_UN:  if (root_a != root_b) par_mem[root_b] <= root_a;
      default: ;
    endcase
    case (op)
      kfvh_pkg::OP_LR: rd_par <= par_mem[nidx[kfvh_pkg::PADDR_W-1:0]];
      default:         rd_par <= par_mem[cur[kfvh_pkg::PADDR_W-1:0]];
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= kfvh_pkg::NODE_W'(1);
      hub_cost   <= '0;
    end else if (cfg_take) begin
      case (cfg_index)
        kfvh_pkg::REG_NODE_COUNT: node_count <= cfg_data[kfvh_pkg::NODE_W-1:0];
        kfvh_pkg::REG_HUB_COST:   hub_cost   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      kfvh_pkg::OP_SC: begin
        dig <= src_dig;
        ew  <= src;
      end
      kfvh_pkg::OP_HC: dig <= src_dig;
      kfvh_pkg::OP_KC: begin
        ew  <= rd_a;
        cur <= ka;
      end
      kfvh_pkg::OP_FC: begin
        if (st.root_hit) begin
          if (side) root_b <= cur;
          else      root_a <= cur;
          cur <= side ? kfvh_pkg::edge_b(ew) : kfvh_pkg::edge_a(ew);
        end else begin
          cur <= rd_par;
        end
      end
      kfvh_pkg::OP_PCW: begin
        if (!st.comp_end)  cur <= rd_par;
        else if (!side)    cur <= kfvh_pkg::edge_b(ew);
      end
      kfvh_pkg::OP_CC: run <= '0;
      kfvh_pkg::OP_PW: run <= run + rd_cnt;
      default: ;
    endcase
  end

  // Control counters, accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      lost      <= 1'b0;
      pass      <= 1'b0;
      side      <= 1'b0;
      didx      <= '0;
      idx       <= '0;
      nidx      <= '0;
      links     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      case (op)
        kfvh_pkg::OP_CLR: begin
          nidx  <= st.clr_last ? '0 : nidx + 1'b1;
          total <= '0;
          idx   <= '0;
        end
        kfvh_pkg::OP_IDLE: begin
          if (in_take && edge_valid) begin
            if (fill == kfvh_pkg::FILL_W'(kfvh_pkg::MAX_EDGES)) lost <= 1'b1;
            else                                               fill <= fill + 1'b1;
          end
        end
        kfvh_pkg::OP_CC: begin
          didx <= didx + 1'b1;
          if (st.didx_last) idx <= '0;
        end
        kfvh_pkg::OP_HW, kfvh_pkg::OP_SW: idx <= idx + 1'b1;
        kfvh_pkg::OP_PW: begin
          didx <= didx + 1'b1;
          if (st.didx_last) idx <= '0;
        end
        kfvh_pkg::OP_SR: begin
          if (st.idx_end) begin
            pass <= 1'b1;
            idx  <= '0;
          end
        end
        kfvh_pkg::OP_KR: begin
          side <= 1'b0;
          if (st.idx_end) begin
            nidx  <= kfvh_pkg::NODE_W'(1);
            links <= '0;
          end
        end
        kfvh_pkg::OP_KC: if (!st.edge_ok) idx <= idx + 1'b1;
        kfvh_pkg::OP_PCW: if (st.comp_end) side <= 1'b1;
        kfvh_pkg::OP_UN: begin
          idx <= idx + 1'b1;
          if (root_a != root_b)
            total <= total + kfvh_pkg::TOT_W'(kfvh_pkg::edge_wgt(ew));
        end
        kfvh_pkg::OP_LC: begin
          nidx <= nidx + 1'b1;
          if (rd_par == nidx) begin
            links <= links + 1'b1;
            total <= total + kfvh_pkg::TOT_W'(hub_cost);
          end
        end
        kfvh_pkg::OP_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            nidx      <= '0;
            fill      <= '0;
            lost      <= 1'b0;
            pass      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == kfvh_pkg::OP_DONE && !out_valid) begin
      total_cost <= total[kfvh_pkg::TOT_W-1] ? '1 : total[31:0];
      hub_links  <= links;
      overflow   <= lost | total[kfvh_pkg::TOT_W-1];
    end
  end

endmodule

/* src/kruskal_forest_with_virtual_hub.sv */
// Minimum spanning forest with a virtual hub: radix sort plus union-find.
// Loading accepts one edge per cycle. After the last item: two radix passes,
// then Kruskal, with a find and a path compression for each endpoint of a
// candidate edge and then a union, then a root count over the nodes, then a
// sweep that clears the parent table (also run after reset, with input tready low).
// Reset: synchronous, active high; node_count=1, hub_cost=0, store empty.
module kruskal_forest_with_virtual_hub (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kfvh_pkg::S_DATA_W-1:0]   s_tdata,  // endpoint_a, endpoint_b, edge_weight, pad
  input  logic                            s_tuser,  // edge_valid
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kfvh_pkg::M_DATA_W-1:0]   m_tdata,  // total_cost, hub_links, pad
  output logic                            m_tuser,  // overflow
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  kfvh_pkg::reg_t                  cfg_index,
  input  logic [kfvh_pkg::WGT_W-1:0]      cfg_data
);

  kfvh_pkg::op_t   op;
  kfvh_pkg::stat_t st;
  logic [31:0]                    total_cost;
  logic [kfvh_pkg::NODE_W-1:0]    hub_links;
  logic                           in_take;

  assign in_take   = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  kfvh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .st       (st),
    .s_tready (s_tready),
    .op       (op)
  );

  kfvh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .in_take     (in_take),
    .edge_valid  (s_tuser),
    .endpoint_a  (s_tdata[10:0]),
    .endpoint_b  (s_tdata[21:11]),
    .edge_weight (s_tdata[37:22]),
    .cfg_take    (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_take    (m_tvalid & m_tready),
    .out_valid   (m_tvalid),
    .total_cost  (total_cost),
    .hub_links   (hub_links),
    .overflow    (m_tuser),
    .st          (st)
  );

  assign m_tdata = {5'b0, hub_links, total_cost};

`ifndef ASSERT_OFF
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(op == kfvh_pkg::OP_DONE))
    else $error("result raised outside the finish step");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (in_take && s_tlast) |=> (op == kfvh_pkg::OP_CC))
    else $error("closing transaction did not start the sort");

  a_links_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hub_links <= kfvh_pkg::NODE_W'(kfvh_pkg::MAX_NODES)))
    else $error("hub link count out of range");
`endif

endmodule
